// ----- hw/rtl/gdoc_pkg.sv -----
package gdoc_pkg;

	// Field widths of the transaction payloads
	localparam int YEAR_W  = 14;
	localparam int MONTH_W = 4;
	localparam int DAY_W   = 5;
	localparam int OFF_W   = 20;
	localparam int DIFF_W  = 23;

	localparam int MAX_YEAR_DEF = 9999;

	// Calendar block lengths in days
	localparam int BLEN_W = 18;
	localparam logic [BLEN_W-1:0] DAYS_400  = 18'd146097;
	localparam logic [BLEN_W-1:0] DAYS_100L = 18'd36525;
	localparam logic [BLEN_W-1:0] DAYS_100  = 18'd36524;
	localparam logic [BLEN_W-1:0] DAYS_4L   = 18'd1461;
	localparam logic [BLEN_W-1:0] DAYS_4    = 18'd1460;
	localparam logic [BLEN_W-1:0] DAYS_1L   = 18'd366;
	localparam logic [BLEN_W-1:0] DAYS_1    = 18'd365;

	// Year steps of the block levels
	localparam int STEP_W = 9;
	localparam logic [STEP_W-1:0] YEARS_400 = 9'd400;
	localparam logic [STEP_W-1:0] YEARS_100 = 9'd100;
	localparam logic [STEP_W-1:0] YEARS_4   = 9'd4;
	localparam logic [STEP_W-1:0] YEARS_1   = 9'd1;

	localparam logic [MONTH_W-1:0] MONTHS = 4'd12;

	typedef enum logic [3:0] {
		OP_NOP,
		OP_LOAD_A,
		OP_LOAD_B,
		OP_FWD_Y,
		OP_FWD_M,
		OP_END,
		OP_SHIFT,
		OP_CHECK,
		OP_INV_Y,
		OP_INV_M,
		OP_EMIT
	} op_t;

	typedef enum logic [1:0] {
		LV_400,
		LV_100,
		LV_4,
		LV_1
	} lvl_t;

	typedef enum logic [3:0] {
		C_NEVER,
		C_ALWAYS,
		C_IDLE,
		C_FWD_Y,
		C_FWD_M,
		C_SEL_B,
		C_BAD,
		C_INV_Y,
		C_INV_M,
		C_OUT_BUSY
	} cond_t;

	// Loop: repeat the operation while the condition holds, then fall through.
	// Jump: do the operation once, branch when the condition holds.
	typedef enum logic {
		M_LOOP,
		M_JUMP
	} mode_t;

	localparam int PC_W = 5;
	typedef logic [PC_W-1:0] pc_t;

	// Program step addresses
	localparam pc_t ST_IDLE     = 5'd0;
	localparam pc_t ST_LOAD_A   = 5'd1;
	localparam pc_t ST_FWD_400  = 5'd2;
	localparam pc_t ST_FWD_100  = 5'd3;
	localparam pc_t ST_FWD_4    = 5'd4;
	localparam pc_t ST_FWD_1    = 5'd5;
	localparam pc_t ST_FWD_MON  = 5'd6;
	localparam pc_t ST_END      = 5'd7;
	localparam pc_t ST_LOAD_B   = 5'd8;
	localparam pc_t ST_SHIFT    = 5'd9;
	localparam pc_t ST_CHECK    = 5'd10;
	localparam pc_t ST_INV_400  = 5'd11;
	localparam pc_t ST_INV_100  = 5'd12;
	localparam pc_t ST_INV_4    = 5'd13;
	localparam pc_t ST_INV_1    = 5'd14;
	localparam pc_t ST_INV_MON  = 5'd15;
	localparam pc_t ST_WAIT     = 5'd16;
	localparam pc_t ST_EMIT     = 5'd17;

	typedef struct packed {
		op_t   op;
		lvl_t  lvl;
		cond_t cond;
		mode_t mode;
		pc_t   target;
	} uword_t;

	// Datapath conditions seen by the sequencer
	typedef struct packed {
		logic idle;
		logic fwd_y;
		logic fwd_m;
		logic sel_b;
		logic bad;
		logic inv_y;
		logic inv_m;
		logic out_busy;
	} stat_t;

	// Control handed to the datapath
	typedef struct packed {
		op_t  op;
		lvl_t lvl;
		logic exec;
		logic idle;
	} ctrl_t;

	// Control store
	function automatic uword_t ucode(pc_t pc);
		uword_t w;
		w = '{op: OP_NOP, lvl: LV_400, cond: C_ALWAYS, mode: M_JUMP, target: ST_IDLE};
		unique case (pc)
			ST_IDLE:    w = '{OP_NOP,    LV_400, C_IDLE,     M_LOOP, ST_IDLE};
			ST_LOAD_A:  w = '{OP_LOAD_A, LV_400, C_NEVER,    M_JUMP, ST_IDLE};
			ST_FWD_400: w = '{OP_FWD_Y,  LV_400, C_FWD_Y,    M_LOOP, ST_IDLE};
			ST_FWD_100: w = '{OP_FWD_Y,  LV_100, C_FWD_Y,    M_LOOP, ST_IDLE};
			ST_FWD_4:   w = '{OP_FWD_Y,  LV_4,   C_FWD_Y,    M_LOOP, ST_IDLE};
			ST_FWD_1:   w = '{OP_FWD_Y,  LV_1,   C_FWD_Y,    M_LOOP, ST_IDLE};
			ST_FWD_MON: w = '{OP_FWD_M,  LV_400, C_FWD_M,    M_LOOP, ST_IDLE};
			ST_END:     w = '{OP_END,    LV_400, C_SEL_B,    M_JUMP, ST_SHIFT};
			ST_LOAD_B:  w = '{OP_LOAD_B, LV_400, C_ALWAYS,   M_JUMP, ST_FWD_400};
			ST_SHIFT:   w = '{OP_SHIFT,  LV_400, C_NEVER,    M_JUMP, ST_IDLE};
			ST_CHECK:   w = '{OP_CHECK,  LV_400, C_BAD,      M_JUMP, ST_WAIT};
			ST_INV_400: w = '{OP_INV_Y,  LV_400, C_INV_Y,    M_LOOP, ST_IDLE};
			ST_INV_100: w = '{OP_INV_Y,  LV_100, C_INV_Y,    M_LOOP, ST_IDLE};
			ST_INV_4:   w = '{OP_INV_Y,  LV_4,   C_INV_Y,    M_LOOP, ST_IDLE};
			ST_INV_1:   w = '{OP_INV_Y,  LV_1,   C_INV_Y,    M_LOOP, ST_IDLE};
			ST_INV_MON: w = '{OP_INV_M,  LV_400, C_INV_M,    M_LOOP, ST_IDLE};
			ST_WAIT:    w = '{OP_NOP,    LV_400, C_OUT_BUSY, M_LOOP, ST_IDLE};
			ST_EMIT:    w = '{OP_EMIT,   LV_400, C_ALWAYS,   M_JUMP, ST_IDLE};
			default:    w = '{OP_NOP,    LV_400, C_ALWAYS,   M_JUMP, ST_IDLE};
		endcase
		return w;
	endfunction

	// Days in a month; zero for a month code outside the calendar
	function automatic logic [DAY_W-1:0] month_len(logic [MONTH_W-1:0] m, logic leap);
		logic [DAY_W-1:0] len;
		case (m) inside
			4'd1, 4'd3, 4'd5, 4'd7, 4'd8, 4'd10, 4'd12: len = 5'd31;
			4'd4, 4'd6, 4'd9, 4'd11:                    len = 5'd30;
			4'd2:                                       len = leap ? 5'd29 : 5'd28;
			default:                                    len = 5'd0;
		endcase
		return len;
	endfunction

	// Days from year 0 January 1 to January 1 of year y, for sizing
	function automatic int days_before_year(int y);
		int p;
		p = y - 1;
		if (y <= 0) begin
			return 0;
		end
		return 365 * y + p / 4 - p / 100 + p / 400 + 1;
	endfunction

endpackage

// ----- hw/rtl/gdoc_req_if.sv -----
interface gdoc_req_if;
	import gdoc_pkg::*;

	logic                        valid;
	logic                        ready;
	logic [YEAR_W-1:0]           first_year;
	logic [MONTH_W-1:0]          first_month;
	logic [DAY_W-1:0]            first_day;
	logic [YEAR_W-1:0]           second_year;
	logic [MONTH_W-1:0]          second_month;
	logic [DAY_W-1:0]            second_day;
	logic signed [OFF_W-1:0]     day_offset;

	modport source (
		output valid, first_year, first_month, first_day,
		       second_year, second_month, second_day, day_offset,
		input  ready
	);

	modport sink (
		input  valid, first_year, first_month, first_day,
		       second_year, second_month, second_day, day_offset,
		output ready
	);
endinterface

// ----- hw/rtl/gdoc_rsp_if.sv -----
interface gdoc_rsp_if;
	import gdoc_pkg::*;

	logic                        valid;
	logic                        ready;
	logic [YEAR_W-1:0]           result_year;
	logic [MONTH_W-1:0]          result_month;
	logic [DAY_W-1:0]            result_day;
	logic                        first_less;
	logic                        dates_equal;
	logic signed [DIFF_W-1:0]    difference_days;
	logic                        input_valid;
	logic                        out_of_range;

	modport source (
		output valid, result_year, result_month, result_day, first_less,
		       dates_equal, difference_days, input_valid, out_of_range,
		input  ready
	);

	modport sink (
		input  valid, result_year, result_month, result_day, first_less,
		       dates_equal, difference_days, input_valid, out_of_range,
		output ready
	);
endinterface

// ----- hw/rtl/gdoc_useq.sv -----
module gdoc_useq (
	input  logic            clk,
	input  logic            arst_n,
	input  gdoc_pkg::stat_t stat,
	output gdoc_pkg::ctrl_t ctrl
);
	import gdoc_pkg::*;

	pc_t    pc_q;
	pc_t    pc_next;
	uword_t uw;
	logic   hit;

	assign uw = ucode(pc_q);

	// Select the branch condition of the current step
	always_comb begin
		unique case (uw.cond)
			C_NEVER:    hit = 1'b0;
			C_ALWAYS:   hit = 1'b1;
			C_IDLE:     hit = stat.idle;
			C_FWD_Y:    hit = stat.fwd_y;
			C_FWD_M:    hit = stat.fwd_m;
			C_SEL_B:    hit = stat.sel_b;
			C_BAD:      hit = stat.bad;
			C_INV_Y:    hit = stat.inv_y;
			C_INV_M:    hit = stat.inv_m;
			C_OUT_BUSY: hit = stat.out_busy;
			default:    hit = 1'b0;
		endcase
	end

	// Hold on a looping step, branch or advance otherwise
	always_comb begin
		if (uw.mode == M_LOOP) begin
			pc_next = hit ? pc_q : pc_q + PC_W'(1);
		end else begin
			pc_next = hit ? uw.target : pc_q + PC_W'(1);
		end
	end

	assign ctrl.op   = uw.op;
	assign ctrl.lvl  = uw.lvl;
	assign ctrl.exec = (uw.mode == M_JUMP) || hit;
	assign ctrl.idle = (pc_q == ST_IDLE);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pc_q <= ST_IDLE;
		end else begin
			pc_q <= pc_next;
		end
	end
endmodule

// ----- hw/rtl/gregorian_date_offset_compare.sv -----
// Gregorian date shift and compare. One request transaction carries two dates
// and a signed day offset; one response transaction returns the first date moved
// by the offset, the less/equal flags and the day difference first minus second.
// Each date is turned into a day count from 0000-01-01 and the shifted count back
// into a date by a microcoded sequencer that steps one accumulator over 400-,
// 100-, 4- and 1-year blocks and then over months, one block a cycle. A
// response that is not yet taken holds the sequencer before it loads the next
// one. The block takes one item at a time; the response register lets the
// next request in while a result still waits. Invalid input dates give
// input_valid 0 and all other fields 0; a shift outside years 0..MAX_YEAR gives
// out_of_range 1 with a zero date and the compare fields still valid.
module gregorian_date_offset_compare #(
	parameter int MAX_YEAR = gdoc_pkg::MAX_YEAR_DEF
) (
	input logic        clk,
	input logic        arst_n,
	gdoc_req_if.sink   req,
	gdoc_rsp_if.source rsp
);
	import gdoc_pkg::*;

	localparam int YR_W     = ($clog2(MAX_YEAR + 1) > YEAR_W) ? $clog2(MAX_YEAR + 1) : YEAR_W;
	localparam int DAYS_END = days_before_year(MAX_YEAR + 1);
	localparam int DAYS_IN  = days_before_year(2 ** YEAR_W);
	localparam int SPAN     = ((DAYS_END > DAYS_IN) ? DAYS_END : DAYS_IN) + 2 ** (OFF_W - 1);
	localparam int DN_W     = $clog2(SPAN + 1) + 1;

	localparam logic signed [DN_W-1:0] END_DN = DN_W'(DAYS_END);
	localparam logic signed [DN_W-1:0] ONE_DN = DN_W'(1);

	ctrl_t ctrl;
	stat_t stat;

	// Captured request
	logic [YEAR_W-1:0]       fy_q, sy_q;
	logic [MONTH_W-1:0]      fm_q, sm_q;
	logic [DAY_W-1:0]        fd_q, sd_q;
	logic signed [OFF_W-1:0] off_q;

	// Working registers
	logic                    sel_q;
	logic signed [DN_W-1:0]  acc_q;
	logic [YR_W-1:0]         cnt_q;
	logic [MONTH_W-1:0]      mo_q;
	logic                    cf_q, qf_q, yf_q;
	logic signed [DN_W-1:0]  n1_q, n2_q;
	logic                    va_q, vb_q, oor_q;

	// Response register
	logic                    ov_q;
	logic [YEAR_W-1:0]       ry_q;
	logic [MONTH_W-1:0]      rm_q;
	logic [DAY_W-1:0]        rd_q;
	logic                    less_q, eq_q, iv_q, ro_q;
	logic signed [DIFF_W-1:0] diff_q;

	logic [YEAR_W-1:0]       cur_y;
	logic [MONTH_W-1:0]      cur_m;
	logic [DAY_W-1:0]        cur_d;
	logic                    leap;
	logic [BLEN_W-1:0]       blen;
	logic [STEP_W-1:0]       step;
	logic signed [DN_W-1:0]  blen_dn;
	logic [YR_W-1:0]         step_yr;
	logic [DAY_W-1:0]        mlen_cur, mlen_tgt;
	logic signed [DN_W-1:0]  mlen_dn;
	logic signed [DN_W-1:0]  cur_d_dn;
	logic                    date_ok;
	logic                    ns_out;
	logic signed [DN_W-1:0]  diff_full;

	gdoc_useq u_useq (
		.clk    (clk),
		.arst_n (arst_n),
		.stat   (stat),
		.ctrl   (ctrl)
	);

	// Date under conversion and the leap flag of the current year
	assign cur_y = sel_q ? sy_q : fy_q;
	assign cur_m = sel_q ? sm_q : fm_q;
	assign cur_d = sel_q ? sd_q : fd_q;
	assign leap  = yf_q && (cf_q || !qf_q);

	// Length and year step of the block at the current level
	always_comb begin
		unique case (ctrl.lvl)
			LV_400: begin
				blen = DAYS_400;
				step = YEARS_400;
			end
			LV_100: begin
				blen = cf_q ? DAYS_100L : DAYS_100;
				step = YEARS_100;
			end
			LV_4: begin
				blen = (cf_q || !qf_q) ? DAYS_4L : DAYS_4;
				step = YEARS_4;
			end
			LV_1: begin
				blen = leap ? DAYS_1L : DAYS_1;
				step = YEARS_1;
			end
			default: begin
				blen = DAYS_1;
				step = YEARS_1;
			end
		endcase
	end

	assign blen_dn  = $signed({{(DN_W - BLEN_W){1'b0}}, blen});
	assign step_yr  = YR_W'(step);
	assign mlen_cur = month_len(mo_q, leap);
	assign mlen_tgt = month_len(cur_m, leap);
	assign mlen_dn  = $signed({{(DN_W - DAY_W){1'b0}}, mlen_cur});
	assign cur_d_dn = $signed({{(DN_W - DAY_W){1'b0}}, cur_d});

	assign date_ok = (32'(cur_y) <= 32'(MAX_YEAR)) && (cur_m != '0) && (cur_m <= MONTHS)
		&& (cur_d != '0) && (cur_d <= mlen_tgt);
	assign ns_out  = (acc_q < 0) || (acc_q >= END_DN);
	assign diff_full = n1_q - n2_q;

	// Conditions for the sequencer
	assign stat.idle     = !req.valid;
	assign stat.fwd_y    = cnt_q >= step_yr;
	assign stat.fwd_m    = (mo_q < cur_m) && (mo_q <= MONTHS);
	assign stat.sel_b    = sel_q;
	assign stat.bad      = !(va_q && vb_q) || ns_out;
	assign stat.inv_y    = acc_q >= blen_dn;
	assign stat.inv_m    = (mo_q < MONTHS) && (acc_q >= mlen_dn);
	assign stat.out_busy = ov_q && !rsp.ready;

	assign req.ready = ctrl.idle;

	// Capture the request transaction
	always_ff @(posedge clk) begin
		if (req.valid && req.ready) begin
			fy_q  <= req.first_year;
			fm_q  <= req.first_month;
			fd_q  <= req.first_day;
			sy_q  <= req.second_year;
			sm_q  <= req.second_month;
			sd_q  <= req.second_day;
			off_q <= req.day_offset;
		end
	end

	// Execute the control word on the datapath
	always_ff @(posedge clk) begin
		if (ctrl.exec) begin
			unique case (ctrl.op) inside
				OP_LOAD_A, OP_LOAD_B: begin
					sel_q <= (ctrl.op == OP_LOAD_B);
					cnt_q <= YR_W'((ctrl.op == OP_LOAD_B) ? sy_q : fy_q);
					acc_q <= '0;
					mo_q  <= MONTH_W'(1);
					cf_q  <= 1'b1;
					qf_q  <= 1'b1;
					yf_q  <= 1'b1;
				end
				OP_FWD_Y, OP_INV_Y: begin
					if (ctrl.op == OP_FWD_Y) begin
						cnt_q <= cnt_q - step_yr;
						acc_q <= acc_q + blen_dn;
					end else begin
						cnt_q <= cnt_q + step_yr;
						acc_q <= acc_q - blen_dn;
					end
					case (ctrl.lvl)
						LV_100:  cf_q <= 1'b0;
						LV_4:    qf_q <= 1'b0;
						LV_1:    yf_q <= 1'b0;
						default: ;
					endcase
				end
				OP_FWD_M: begin
					acc_q <= acc_q + mlen_dn;
					mo_q  <= mo_q + MONTH_W'(1);
				end
				OP_INV_M: begin
					acc_q <= acc_q - mlen_dn;
					mo_q  <= mo_q + MONTH_W'(1);
				end
				OP_END: begin
					if (sel_q) begin
						n2_q <= acc_q + cur_d_dn - ONE_DN;
						vb_q <= date_ok;
					end else begin
						n1_q <= acc_q + cur_d_dn - ONE_DN;
						va_q <= date_ok;
					end
				end
				OP_SHIFT: begin
					acc_q <= n1_q + $signed({{(DN_W - OFF_W){off_q[OFF_W-1]}}, off_q});
					cnt_q <= '0;
					mo_q  <= MONTH_W'(1);
					cf_q  <= 1'b1;
					qf_q  <= 1'b1;
					yf_q  <= 1'b1;
				end
				OP_CHECK: begin
					oor_q <= va_q && vb_q && ns_out;
				end
				default: ;
			endcase
		end
	end

	// Load the response register
	always_ff @(posedge clk) begin
		if (ctrl.exec && ctrl.op == OP_EMIT) begin
			if (!(va_q && vb_q)) begin
				ry_q   <= '0;
				rm_q   <= '0;
				rd_q   <= '0;
				less_q <= 1'b0;
				eq_q   <= 1'b0;
				diff_q <= '0;
				iv_q   <= 1'b0;
				ro_q   <= 1'b0;
			end else begin
				if (oor_q) begin
					ry_q <= '0;
					rm_q <= '0;
					rd_q <= '0;
				end else begin
					ry_q <= cnt_q[YEAR_W-1:0];
					rm_q <= mo_q;
					rd_q <= acc_q[DAY_W-1:0] + DAY_W'(1);
				end
				less_q <= n1_q < n2_q;
				eq_q   <= n1_q == n2_q;
				diff_q <= diff_full[DIFF_W-1:0];
				iv_q   <= 1'b1;
				ro_q   <= oor_q;
			end
		end
	end

	// Hold the response valid until the transaction completes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ov_q <= 1'b0;
		end else if (ctrl.exec && ctrl.op == OP_EMIT) begin
			ov_q <= 1'b1;
		end else if (rsp.ready) begin
			ov_q <= 1'b0;
		end
	end

	assign rsp.valid           = ov_q;
	assign rsp.result_year     = ry_q;
	assign rsp.result_month    = rm_q;
	assign rsp.result_day      = rd_q;
	assign rsp.first_less      = less_q;
	assign rsp.dates_equal     = eq_q;
	assign rsp.difference_days = diff_q;
	assign rsp.input_valid     = iv_q;
	assign rsp.out_of_range    = ro_q;
endmodule

// ----- bench/tb_gregorian_date_offset_compare.sv -----
`timescale 1ns / 100ps

module tb_gregorian_date_offset_compare;
	import gdoc_pkg::*;

	localparam int LAST_YEAR    = MAX_YEAR_DEF;
	localparam int DRAIN_CYCLES = 400;
	localparam int RANDOM_ITEMS = 1500;
	localparam int REPORT_LIMIT = 10;

	typedef struct packed {
		logic [YEAR_W-1:0]       first_year;
		logic [MONTH_W-1:0]      first_month;
		logic [DAY_W-1:0]        first_day;
		logic [YEAR_W-1:0]       second_year;
		logic [MONTH_W-1:0]      second_month;
		logic [DAY_W-1:0]        second_day;
		logic signed [OFF_W-1:0] day_offset;
	} date_query_t;

	typedef struct packed {
		logic [YEAR_W-1:0]        result_year;
		logic [MONTH_W-1:0]       result_month;
		logic [DAY_W-1:0]         result_day;
		logic                     first_less;
		logic                     dates_equal;
		logic signed [DIFF_W-1:0] difference_days;
		logic                     input_valid;
		logic                     out_of_range;
	} date_answer_t;

	typedef struct {
		date_query_t query;
		bit          wait_for_drain;
	} pending_query_t;

	logic clk = 1'b0;
	logic arst_n;

	gdoc_req_if req_ch ();
	gdoc_rsp_if rsp_ch ();

	gregorian_date_offset_compare #(
		.MAX_YEAR(LAST_YEAR)
	) dut (
		.clk(clk),
		.arst_n(arst_n),
		.req(req_ch),
		.rsp(rsp_ch)
	);

	pending_query_t query_q[$];
	date_answer_t   answer_q[$];
	int             error_count = 0;
	int             send_gap;
	int             stall_left;
	int             stall_draw;
	bit             quiet_mode = 1'b0;

	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	// ---------------------------------------------------------------
	// Calendar arithmetic
	// ---------------------------------------------------------------
	function automatic bit leap_year(longint y);
		return ((y % 4 == 0) && (y % 100 != 0)) || (y % 400 == 0);
	endfunction

	function automatic int month_days(longint y, int m);
		case (m)
			1, 3, 5, 7, 8, 10, 12: return 31;
			4, 6, 9, 11:           return 30;
			2:                     return leap_year(y) ? 29 : 28;
			default:               return 0;
		endcase
	endfunction

	// Ordinal of January 1 of year y; leap years before y counted by ceilings
	function automatic longint jan1_ordinal(longint y);
		return 365 * y + (y + 3) / 4 - (y + 99) / 100 + (y + 399) / 400;
	endfunction

	function automatic bit date_legal(longint y, int m, int d);
		return (y <= LAST_YEAR) && (m >= 1) && (m <= 12) && (d >= 1)
			&& (d <= month_days(y, m));
	endfunction

	function automatic longint day_ordinal(longint y, int m, int d);
		longint n;
		n = jan1_ordinal(y);
		for (int k = 1; k < m; k++) begin
			n += month_days(y, k);
		end
		return n + d - 1;
	endfunction

	function automatic void ordinal_to_date(longint n, output logic [YEAR_W-1:0] y,
			output logic [MONTH_W-1:0] m, output logic [DAY_W-1:0] d);
		longint yy;
		longint rest;
		int     mm;
		yy = (n * 400) / 146097;
		while (jan1_ordinal(yy + 1) <= n) begin
			yy++;
		end
		while (yy > 0 && jan1_ordinal(yy) > n) begin
			yy--;
		end
		rest = n - jan1_ordinal(yy);
		mm = 1;
		while (mm < 12 && rest >= month_days(yy, mm)) begin
			rest -= month_days(yy, mm);
			mm++;
		end
		y = YEAR_W'(yy);
		m = MONTH_W'(mm);
		d = DAY_W'(rest + 1);
	endfunction

	// Shift, compare and difference for one query
	function automatic date_answer_t predict_answer(date_query_t q);
		date_answer_t a;
		longint       n1;
		longint       n2;
		longint       ns;
		a = '0;
		if (!date_legal(q.first_year, q.first_month, q.first_day)
				|| !date_legal(q.second_year, q.second_month, q.second_day)) begin
			return a;
		end
		n1 = day_ordinal(q.first_year, q.first_month, q.first_day);
		n2 = day_ordinal(q.second_year, q.second_month, q.second_day);
		ns = n1 + longint'($signed(q.day_offset));
		if (ns < 0 || ns >= jan1_ordinal(LAST_YEAR + 1)) begin
			a.out_of_range = 1'b1;
		end else begin
			ordinal_to_date(ns, a.result_year, a.result_month, a.result_day);
		end
		a.first_less      = (n1 < n2);
		a.dates_equal     = (n1 == n2);
		a.difference_days = DIFF_W'(n1 - n2);
		a.input_valid     = 1'b1;
		return a;
	endfunction

	// ---------------------------------------------------------------
	// Stimulus construction
	// ---------------------------------------------------------------
	function automatic int draw_gap(int long_max);
		int r;
		if ($urandom_range(0, 49) == 0) begin
			quiet_mode = !quiet_mode;
		end
		r = $urandom_range(0, 99);
		if (quiet_mode || r < 60) begin
			return 0;
		end else if (r < 90) begin
			return $urandom_range(1, 3);
		end else if (r < 98) begin
			return $urandom_range(4, 12);
		end
		return $urandom_range(40, long_max);
	endfunction

	task automatic add_query(int fy, int fm, int fd, int sy, int sm, int sd, int off);
		pending_query_t p;
		p.query = '{first_year: YEAR_W'(fy), first_month: MONTH_W'(fm),
			first_day: DAY_W'(fd), second_year: YEAR_W'(sy),
			second_month: MONTH_W'(sm), second_day: DAY_W'(sd),
			day_offset: OFF_W'(off)};
		p.wait_for_drain = 1'b0;
		query_q.push_back(p);
	endtask

	function automatic void random_date(output logic [YEAR_W-1:0] y,
			output logic [MONTH_W-1:0] m, output logic [DAY_W-1:0] d);
		int r;
		int len;
		r = $urandom_range(0, 99);
		if (r < 70) begin
			y = YEAR_W'($urandom_range(0, LAST_YEAR));
		end else if (r < 80) begin
			y = YEAR_W'($urandom_range(0, 3));
		end else if (r < 90) begin
			y = YEAR_W'($urandom_range(LAST_YEAR - 3, LAST_YEAR));
		end else begin
			y = YEAR_W'($urandom_range(0, LAST_YEAR / 100) * 100);
		end
		m = MONTH_W'($urandom_range(1, 12));
		len = month_days(y, m);
		d = DAY_W'(($urandom_range(0, 6) == 0) ? len : int'($urandom_range(1, len)));
	endfunction

	function automatic date_query_t random_query();
		date_query_t             q;
		logic signed [OFF_W-1:0] raw_off;
		longint                  target;
		longint                  off;
		int                      r;
		random_date(q.first_year, q.first_month, q.first_day);
		if ($urandom_range(0, 99) < 30) begin
			q.second_year  = q.first_year;
			q.second_month = q.first_month;
			q.second_day   = q.first_day;
		end else begin
			random_date(q.second_year, q.second_month, q.second_day);
		end

		// Pick an offset: small, wide, full width, or aimed at a calendar edge
		raw_off = OFF_W'($urandom);
		r = $urandom_range(0, 99);
		if (r < 40) begin
			off = longint'(int'($urandom_range(0, 800)) - 400);
		end else if (r < 70) begin
			off = longint'(raw_off);
		end else if (r < 85) begin
			off = longint'(int'($urandom_range(0, 80000)) - 40000);
		end else begin
			target = $urandom_range(0, 1) ? jan1_ordinal(LAST_YEAR + 1) - 1 : 0;
			target += longint'(int'($urandom_range(0, 2)) - 1);
			off = target - day_ordinal(q.first_year, q.first_month, q.first_day);
			if (off < -(1 << (OFF_W - 1)) || off >= (1 << (OFF_W - 1))) begin
				off = longint'(raw_off);
			end
		end
		q.day_offset = OFF_W'(off);

		// Corrupt one of the dates now and then with raw field bits
		r = $urandom_range(0, 99);
		if (r < 5) begin
			q.first_year  = YEAR_W'($urandom_range(0, (1 << YEAR_W) - 1));
			q.first_month = MONTH_W'($urandom_range(0, (1 << MONTH_W) - 1));
			q.first_day   = DAY_W'($urandom_range(0, (1 << DAY_W) - 1));
		end else if (r < 9) begin
			q.second_year  = YEAR_W'($urandom_range(0, (1 << YEAR_W) - 1));
			q.second_month = MONTH_W'($urandom_range(0, (1 << MONTH_W) - 1));
			q.second_day   = DAY_W'($urandom_range(0, (1 << DAY_W) - 1));
		end
		return q;
	endfunction

	// ---------------------------------------------------------------
	// Request driver
	// ---------------------------------------------------------------
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			req_ch.valid        <= 1'b0;
			req_ch.first_year   <= '0;
			req_ch.first_month  <= '0;
			req_ch.first_day    <= '0;
			req_ch.second_year  <= '0;
			req_ch.second_month <= '0;
			req_ch.second_day   <= '0;
			req_ch.day_offset   <= '0;
			send_gap            <= 0;
		end else begin
			// Record the expected answer of an accepted transaction
			if (req_ch.valid && req_ch.ready) begin
				answer_q.push_back(predict_answer('{
					first_year: req_ch.first_year, first_month: req_ch.first_month,
					first_day: req_ch.first_day, second_year: req_ch.second_year,
					second_month: req_ch.second_month, second_day: req_ch.second_day,
					day_offset: req_ch.day_offset}));
			end
			// Advance to the next query once the channel is free
			if (!req_ch.valid || req_ch.ready) begin
				if (send_gap != 0) begin
					req_ch.valid <= 1'b0;
					send_gap     <= send_gap - 1;
				end else if (query_q.size() != 0
						&& !(query_q[0].wait_for_drain && answer_q.size() != 0)) begin
					req_ch.valid        <= 1'b1;
					req_ch.first_year   <= query_q[0].query.first_year;
					req_ch.first_month  <= query_q[0].query.first_month;
					req_ch.first_day    <= query_q[0].query.first_day;
					req_ch.second_year  <= query_q[0].query.second_year;
					req_ch.second_month <= query_q[0].query.second_month;
					req_ch.second_day   <= query_q[0].query.second_day;
					req_ch.day_offset   <= query_q[0].query.day_offset;
					void'(query_q.pop_front());
					send_gap <= draw_gap(300);
				end else begin
					req_ch.valid <= 1'b0;
				end
			end
		end
	end

	// ---------------------------------------------------------------
	// Response monitor and checker
	// ---------------------------------------------------------------
	task automatic check_answer(date_answer_t got);
		date_answer_t want;
		bit           bad;
		if (answer_q.size() == 0) begin
			error_count++;
			if (error_count <= REPORT_LIMIT) begin
				$display("%0t: response with no query outstanding: %p", $realtime, got);
			end
			return;
		end
		want = answer_q.pop_front();
		bad = (got.result_year !== want.result_year)
			|| (got.result_month !== want.result_month)
			|| (got.result_day !== want.result_day)
			|| (got.first_less !== want.first_less)
			|| (got.dates_equal !== want.dates_equal)
			|| (got.difference_days !== want.difference_days)
			|| (got.input_valid !== want.input_valid)
			|| (got.out_of_range !== want.out_of_range);
		if (bad) begin
			error_count++;
			if (error_count <= REPORT_LIMIT) begin
				$display("%0t: response mismatch", $realtime);
				$display("  expected date %0d-%0d-%0d less %b equal %b diff %0d valid %b oor %b",
					want.result_year, want.result_month, want.result_day, want.first_less,
					want.dates_equal, want.difference_days, want.input_valid,
					want.out_of_range);
				$display("  actual   date %0d-%0d-%0d less %b equal %b diff %0d valid %b oor %b",
					got.result_year, got.result_month, got.result_day, got.first_less,
					got.dates_equal, got.difference_days, got.input_valid,
					got.out_of_range);
			end
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_ch.ready <= 1'b0;
			stall_left   <= 0;
		end else if (rsp_ch.valid && rsp_ch.ready) begin
			check_answer('{result_year: rsp_ch.result_year,
				result_month: rsp_ch.result_month, result_day: rsp_ch.result_day,
				first_less: rsp_ch.first_less, dates_equal: rsp_ch.dates_equal,
				difference_days: rsp_ch.difference_days, input_valid: rsp_ch.input_valid,
				out_of_range: rsp_ch.out_of_range});
			// Stall for a random stretch after each transaction
			stall_draw    = draw_gap(300);
			stall_left   <= stall_draw;
			rsp_ch.ready <= (stall_draw == 0);
		end else if (!rsp_ch.ready) begin
			if (stall_left <= 1) begin
				rsp_ch.ready <= 1'b1;
			end
			stall_left <= (stall_left > 0) ? stall_left - 1 : 0;
		end
	end

	// ---------------------------------------------------------------
	// Stimulus and end of run
	// ---------------------------------------------------------------
	initial begin
		pending_query_t p;
		arst_n = 1'b0;

		// Directed: leap rules, calendar edges, offset extremes, illegal fields
		add_query(2000, 2, 29, 2000, 2, 29, 0);
		add_query(0, 1, 1, 0, 1, 1, -1);
		add_query(LAST_YEAR, 12, 31, 0, 1, 1, 1);
		add_query(0, 1, 1, LAST_YEAR, 12, 31, 524287);
		add_query(LAST_YEAR, 12, 31, 0, 1, 1, -524288);
		add_query(0, 2, 29, 1, 3, 1, 365);
		add_query(1900, 2, 29, 1900, 3, 1, 1);
		add_query(2100, 2, 28, 2100, 3, 1, 1);
		add_query(2024, 12, 31, 2025, 1, 1, 1);
		add_query(2020, 0, 10, 2020, 1, 10, 5);
		add_query(2020, 13, 10, 2020, 1, 10, 5);
		add_query(16383, 15, 31, 16383, 15, 31, -1);
		add_query(2020, 5, 0, 2020, 5, 1, 3);
		add_query(2023, 4, 31, 2023, 5, 1, 1);
		add_query(LAST_YEAR + 1, 1, 1, 2000, 1, 1, 0);
		add_query(1999, 3, 1, 1999, 2, 29, 10);
		add_query(1999, 12, 31, 2000, 1, 1, -1);
		add_query(2000, 1, 1, 1999, 12, 31, 0);
		add_query(1600, 2, 28, 1600, 2, 28, 1);
		add_query(0, 1, 1, 0, 1, 2, 0);
		add_query(LAST_YEAR, 12, 31, LAST_YEAR, 12, 31, 0);
		add_query(0, 3, 1, 0, 2, 29, -1);
		add_query(5000, 6, 15, 5000, 6, 15, -524288);

		// Random: every 400th one, the first included, held back until earlier answers have drained
		for (int i = 0; i < RANDOM_ITEMS; i++) begin
			p.query          = random_query();
			p.wait_for_drain = (i % 400 == 0);
			query_q.push_back(p);
		end

		repeat (9) @(posedge clk);
		arst_n <= 1'b1;

		// Wait for all queries to go out and all answers to come back
		while (query_q.size() != 0 || req_ch.valid) begin
			@(posedge clk);
		end
		while (answer_q.size() != 0) begin
			@(posedge clk);
		end
		repeat (DRAIN_CYCLES) @(posedge clk);

		if (error_count == 0 && answer_q.size() == 0) begin
			$display("ALL CHECKS PASSED");
		end else begin
			$display("CHECKS FAILED");
		end
		$finish;
	end

	// Watchdog
	initial begin
		#10_000_000;
		$display("CHECKS FAILED");
		$finish;
	end

endmodule
